>>> rtl/mlp_pkg.sv
// Shared types and constants for the perceptron inference block.
package mlp_pkg;

    typedef enum logic [1:0] {
        REQ_WEIGHT  = 2'd0,
        REQ_BIAS    = 2'd1,
        REQ_FEATURE = 2'd2,
        REQ_NONE    = 2'd3
    } req_t;

    localparam logic [1:0] CFG_FEATURES = 2'd0;
    localparam logic [1:0] CFG_HIDDEN1  = 2'd1;
    localparam logic [1:0] CFG_HIDDEN2  = 2'd2;
    localparam logic [1:0] CFG_CLASSES  = 2'd3;

    localparam int FracBits = 11;
    localparam int AccWidth = 64;

    // Datapath commands from the controller.
    typedef struct packed {
        logic       clear;    // load bias into accumulator
        logic       mac;      // accumulate product of read operands
        logic       finish;   // requantize, write activation / compare
        logic [1:0] layer;    // 0, 1 hidden; 2 output
        logic       first;    // first class of output layer
    } mlp_cmd_t;

endpackage

>>> rtl/mlp_ram.sv
// Generic single-port-write, single-read RAM with registered read data.
module mlp_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

>>> rtl/mlp_ctrl.sv
// Sequencer that walks neurons and inputs of the three layers.
module mlp_ctrl import mlp_pkg::*; #(
    parameter int AW = 10
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start,
    input  logic [AW:0]   n_in,
    input  logic [AW:0]   n_h1,
    input  logic [AW:0]   n_h2,
    input  logic [AW:0]   n_cls,
    output logic          busy,
    output logic [AW-1:0] row,
    output logic [AW-1:0] col,
    output mlp_cmd_t      cmd
);
    typedef enum logic [2:0] {S_IDLE, S_BIAS, S_MAC, S_DRAIN, S_FLUSH, S_FIN} state_t;

    state_t        state_reg;
    logic [AW-1:0] row_reg, col_reg;
    logic [1:0]    layer_reg;
    logic [AW:0]   n_col, n_row;

    always_comb begin
        case (layer_reg)
            2'd0:    begin n_col = n_in; n_row = n_h1;  end
            2'd1:    begin n_col = n_h1; n_row = n_h2;  end
            default: begin n_col = n_h2; n_row = n_cls; end
        endcase
    end

    // Reads issued in BIAS/MAC return in the next cycle from the registered RAM output; the datapath aligns.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            row_reg   <= '0;
            col_reg   <= '0;
            layer_reg <= 2'd0;
        end else begin
            case (state_reg)
                S_IDLE: begin
                    if (start) begin
                        state_reg <= S_BIAS;
                        row_reg   <= '0;
                        col_reg   <= '0;
                        layer_reg <= 2'd0;
                    end
                end
                S_BIAS:  state_reg <= S_MAC;
                S_MAC: begin
                    if ({1'b0, col_reg} == n_col - 1'b1) begin
                        state_reg <= S_DRAIN;
                    end else begin
                        col_reg <= col_reg + 1'b1;
                    end
                end
                // Hold in DRAIN and FLUSH so the last product reaches the accumulator.
                S_DRAIN: state_reg <= S_FLUSH;
                S_FLUSH: state_reg <= S_FIN;
                S_FIN: begin
                    col_reg <= '0;
                    if ({1'b0, row_reg} == n_row - 1'b1) begin
                        row_reg <= '0;
                        if (layer_reg == 2'd2) begin
                            state_reg <= S_IDLE;
                        end else begin
                            layer_reg <= layer_reg + 1'b1;
                            state_reg <= S_BIAS;
                        end
                    end else begin
                        row_reg   <= row_reg + 1'b1;
                        state_reg <= S_BIAS;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    logic mac_d_reg, clr_d_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mac_d_reg <= 1'b0;
            clr_d_reg <= 1'b0;
        end else begin
            mac_d_reg <= (state_reg == S_MAC);
            clr_d_reg <= (state_reg == S_BIAS);
        end
    end

    assign busy       = (state_reg != S_IDLE);
    assign row        = row_reg;
    assign col        = col_reg;
    assign cmd.clear  = clr_d_reg;
    assign cmd.mac    = mac_d_reg;
    assign cmd.finish = (state_reg == S_FIN);
    assign cmd.layer  = layer_reg;
    assign cmd.first  = (row_reg == '0);
endmodule

>>> rtl/mlp_dp.sv
// Weight and activation memories, shared multiply-accumulate and argmax.
module mlp_dp import mlp_pkg::*; #(
    parameter int MAX_FEATURES   = 64,
    parameter int MAX_HIDDEN_ONE = 64,
    parameter int MAX_HIDDEN_TWO = 64,
    parameter int MAX_CLASSES    = 16,
    parameter int DATA_WIDTH     = 16,
    parameter int AW             = 10
) (
    input  logic                  aclk,
    input  logic                  load_we,
    input  logic                  load_bias,
    input  logic [1:0]            load_layer,
    input  logic [5:0]            load_row,
    input  logic [5:0]            load_col,
    input  logic [15:0]           load_value,
    input  logic                  feat_we,
    input  logic [AW-1:0]         row,
    input  logic [AW-1:0]         col,
    input  mlp_cmd_t              cmd,
    output logic [3:0]            best_idx,
    output logic signed [15:0]    best_val
);
    localparam int FW  = (MAX_FEATURES   > 1) ? $clog2(MAX_FEATURES)   : 1;
    localparam int H1W = (MAX_HIDDEN_ONE > 1) ? $clog2(MAX_HIDDEN_ONE) : 1;
    localparam int H2W = (MAX_HIDDEN_TWO > 1) ? $clog2(MAX_HIDDEN_TWO) : 1;
    localparam int CW  = $clog2(MAX_CLASSES);
    localparam int DW  = DATA_WIDTH;
    localparam logic signed [AccWidth-1:0] SatMax = (64'sd1 <<< (DW - 1)) - 64'sd1;
    localparam logic signed [AccWidth-1:0] SatMin = -SatMax - 64'sd1;

    logic [15:0] lrow, lcol;
    assign lrow = {10'd0, load_row};
    assign lcol = {10'd0, load_col};

    // Write enables with range checks.
    logic w1_we, w2_we, w3_we, b1_we, b2_we, b3_we;
    assign w1_we = load_we && !load_bias && load_layer == 2'd0
                   && lrow < MAX_HIDDEN_ONE && lcol < MAX_FEATURES;
    assign w2_we = load_we && !load_bias && load_layer == 2'd1
                   && lrow < MAX_HIDDEN_TWO && lcol < MAX_HIDDEN_ONE;
    assign w3_we = load_we && !load_bias && load_layer == 2'd2
                   && lrow < MAX_CLASSES && lcol < MAX_HIDDEN_TWO;
    assign b1_we = load_we && load_bias && load_layer == 2'd0 && lrow < MAX_HIDDEN_ONE;
    assign b2_we = load_we && load_bias && load_layer == 2'd1 && lrow < MAX_HIDDEN_TWO;
    assign b3_we = load_we && load_bias && load_layer == 2'd2 && lrow < MAX_CLASSES;

    logic [DW-1:0] w1_q, w2_q, w3_q, b1_q, b2_q, b3_q, f_q, a1_q, a2_q;
    logic [DW-1:0] ldata, act_data;
    assign ldata = DW'(signed'(load_value));
    logic a1_we, a2_we;

    mlp_ram #(.WIDTH(DW), .DEPTH(MAX_HIDDEN_ONE * MAX_FEATURES)) u_w1 (
        .aclk, .we(w1_we),
        .waddr((H1W + FW)'(load_row) * (H1W + FW)'(MAX_FEATURES) + (H1W + FW)'(load_col)),
        .wdata(ldata),
        .raddr((H1W + FW)'(row) * (H1W + FW)'(MAX_FEATURES) + (H1W + FW)'(col)),
        .rdata(w1_q));
    mlp_ram #(.WIDTH(DW), .DEPTH(MAX_HIDDEN_TWO * MAX_HIDDEN_ONE)) u_w2 (
        .aclk, .we(w2_we),
        .waddr((H2W + H1W)'(load_row) * (H2W + H1W)'(MAX_HIDDEN_ONE) + (H2W + H1W)'(load_col)),
        .wdata(ldata),
        .raddr((H2W + H1W)'(row) * (H2W + H1W)'(MAX_HIDDEN_ONE) + (H2W + H1W)'(col)),
        .rdata(w2_q));
    mlp_ram #(.WIDTH(DW), .DEPTH(MAX_CLASSES * MAX_HIDDEN_TWO)) u_w3 (
        .aclk, .we(w3_we),
        .waddr((CW + H2W)'(load_row) * (CW + H2W)'(MAX_HIDDEN_TWO) + (CW + H2W)'(load_col)),
        .wdata(ldata),
        .raddr((CW + H2W)'(row) * (CW + H2W)'(MAX_HIDDEN_TWO) + (CW + H2W)'(col)),
        .rdata(w3_q));
    mlp_ram #(.WIDTH(DW), .DEPTH(MAX_HIDDEN_ONE)) u_b1 (
        .aclk, .we(b1_we), .waddr(H1W'(load_row)), .wdata(ldata),
        .raddr(H1W'(row)), .rdata(b1_q));
    mlp_ram #(.WIDTH(DW), .DEPTH(MAX_HIDDEN_TWO)) u_b2 (
        .aclk, .we(b2_we), .waddr(H2W'(load_row)), .wdata(ldata),
        .raddr(H2W'(row)), .rdata(b2_q));
    mlp_ram #(.WIDTH(DW), .DEPTH(MAX_CLASSES)) u_b3 (
        .aclk, .we(b3_we), .waddr(CW'(load_row)), .wdata(ldata),
        .raddr(CW'(row)), .rdata(b3_q));
    mlp_ram #(.WIDTH(DW), .DEPTH(MAX_FEATURES)) u_feat (
        .aclk, .we(feat_we && lcol < MAX_FEATURES), .waddr(FW'(load_col)), .wdata(ldata),
        .raddr(FW'(col)), .rdata(f_q));
    mlp_ram #(.WIDTH(DW), .DEPTH(MAX_HIDDEN_ONE)) u_act1 (
        .aclk, .we(a1_we), .waddr(H1W'(row)), .wdata(act_data),
        .raddr(H1W'(col)), .rdata(a1_q));
    mlp_ram #(.WIDTH(DW), .DEPTH(MAX_HIDDEN_TWO)) u_act2 (
        .aclk, .we(a2_we), .waddr(H2W'(row)), .wdata(act_data),
        .raddr(H2W'(col)), .rdata(a2_q));

    // Operand select, product register, accumulator.
    logic signed [DW-1:0]       w_op, x_op, b_op;
    logic signed [2*DW-1:0]     prod_reg;
    logic                       prod_vld_reg;
    logic signed [AccWidth-1:0] acc_reg, acc_next;

    always_comb begin
        case (cmd.layer)
            2'd0:    begin w_op = w1_q; x_op = f_q;  b_op = b1_q; end
            2'd1:    begin w_op = w2_q; x_op = a1_q; b_op = b2_q; end
            default: begin w_op = w3_q; x_op = a2_q; b_op = b3_q; end
        endcase
    end

    always_ff @(posedge aclk) begin
        prod_reg     <= w_op * x_op;
        prod_vld_reg <= cmd.mac;
        acc_reg      <= acc_next;
    end

    always_comb begin
        acc_next = acc_reg;
        if (cmd.clear) begin
            acc_next = AccWidth'(b_op) <<< FracBits;
        end else if (prod_vld_reg) begin
            acc_next = acc_reg + AccWidth'(prod_reg);
        end
    end

    // Round half up, saturate, clamp negatives to zero for activations; the MAC drains in the cycle before finish.
    logic signed [AccWidth-1:0] rnd;
    logic signed [DW-1:0]       sat;
    assign rnd = (acc_reg + (64'sd1 <<< (FracBits - 1))) >>> FracBits;
    assign sat = (rnd > SatMax) ? DW'(SatMax) : (rnd < SatMin) ? DW'(SatMin) : DW'(rnd);
    assign act_data = sat[DW-1] ? '0 : sat;
    assign a1_we = cmd.finish && cmd.layer == 2'd0;
    assign a2_we = cmd.finish && cmd.layer == 2'd1;

    logic [3:0]           bidx_reg;
    logic signed [DW-1:0] bval_reg;
    logic signed [16:0]   sat16;
    always_ff @(posedge aclk) begin
        if (cmd.finish && cmd.layer == 2'd2
            && (cmd.first || sat > bval_reg)) begin
            bidx_reg <= 4'(row);
            bval_reg <= sat;
        end
    end

    assign sat16    = (DW > 16) ? ((bval_reg > $signed(DW'(32767))) ? 17'sd32767 :
                       (bval_reg < -$signed(DW'(32768))) ? -17'sd32768 : 17'(bval_reg))
                      : 17'(bval_reg);
    assign best_idx = bidx_reg;
    assign best_val = sat16[15:0];
endmodule

>>> rtl/mlp_relu_inference_argmax.sv
// Top level: three-layer perceptron inference with argmax result.
// Load and feature beats are written in the cycle they are accepted. A last
// feature starts inference on the single shared MAC; each neuron runs a bias
// read, a MAC step per input, drain, flush and finish. The result beat is
// registered once the sequencer is idle after the last neuron finishes; input
// is held off while inference runs or a result waits. Synchronous active-low
// reset clears control state, restores default counts; memories are not cleared.
module mlp_relu_inference_argmax import mlp_pkg::*; #(
    parameter int MAX_FEATURES   = 64,
    parameter int MAX_HIDDEN_ONE = 64,
    parameter int MAX_HIDDEN_TWO = 64,
    parameter int MAX_CLASSES    = 16,
    parameter int DATA_WIDTH     = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [6:0]         cfg_data,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_req_type,
    input  logic [1:0]         s_layer_sel,
    input  logic [5:0]         s_row_index,
    input  logic [5:0]         s_col_index,
    input  logic signed [15:0] s_value,
    input  logic               s_last,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [3:0]         m_class_index,
    output logic signed [15:0] m_best_logit
);
    localparam int AW = 10;

    logic [6:0] feat_cnt_reg, h1_cnt_reg, h2_cnt_reg;
    logic [4:0] cls_cnt_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            feat_cnt_reg <= 7'd64;
            h1_cnt_reg   <= 7'd64;
            h2_cnt_reg   <= 7'd64;
            cls_cnt_reg  <= 5'd3;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_FEATURES: feat_cnt_reg <= cfg_data;
                CFG_HIDDEN1:  h1_cnt_reg   <= cfg_data;
                CFG_HIDDEN2:  h2_cnt_reg   <= cfg_data;
                CFG_CLASSES:  cls_cnt_reg  <= cfg_data[4:0];
                default:      ;
            endcase
        end
    end

    function automatic logic [AW:0] clamp(input logic [6:0] v, input int mx);
        logic [AW:0] r;
        r = (v == 7'd0) ? (AW+1)'(1) : (AW+1)'(v);
        if (r > (AW+1)'(mx)) r = (AW+1)'(mx);
        return r;
    endfunction

    logic     busy, start, accept, run_reg;
    mlp_cmd_t cmd;
    logic [AW-1:0] row, col;
    logic [3:0]           best_idx;
    logic signed [15:0]   best_val;

    assign s_ready = !busy && !run_reg && !m_valid;
    assign accept  = s_valid && s_ready;
    assign start   = accept && req_t'(s_req_type) == REQ_FEATURE && s_last;

    mlp_ctrl #(.AW(AW)) u_ctrl (
        .aclk, .aresetn, .start,
        .n_in(clamp(feat_cnt_reg, MAX_FEATURES)),
        .n_h1(clamp(h1_cnt_reg, MAX_HIDDEN_ONE)),
        .n_h2(clamp(h2_cnt_reg, MAX_HIDDEN_TWO)),
        .n_cls(clamp({2'b0, cls_cnt_reg}, MAX_CLASSES)),
        .busy, .row, .col, .cmd);

    mlp_dp #(
        .MAX_FEATURES(MAX_FEATURES), .MAX_HIDDEN_ONE(MAX_HIDDEN_ONE),
        .MAX_HIDDEN_TWO(MAX_HIDDEN_TWO), .MAX_CLASSES(MAX_CLASSES),
        .DATA_WIDTH(DATA_WIDTH), .AW(AW)
    ) u_dp (
        .aclk,
        .load_we(accept && (req_t'(s_req_type) == REQ_WEIGHT
                            || req_t'(s_req_type) == REQ_BIAS)),
        .load_bias(req_t'(s_req_type) == REQ_BIAS),
        .load_layer(s_layer_sel), .load_row(s_row_index), .load_col(s_col_index),
        .load_value(s_value),
        .feat_we(accept && req_t'(s_req_type) == REQ_FEATURE),
        .row, .col, .cmd, .best_idx, .best_val);

    // Raise the result beat once the sequencer returns to idle.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg <= 1'b0;
            m_valid <= 1'b0;
        end else begin
            if (start) begin
                run_reg <= 1'b1;
            end else if (run_reg && !busy) begin
                run_reg <= 1'b0;
                m_valid <= 1'b1;
            end
            if (m_valid && m_ready) begin
                m_valid <= 1'b0;
            end
        end
    end

    assign m_class_index = best_idx;
    assign m_best_logit  = best_val;
endmodule

>>> rtl/mlp_checker.sv
// Port-level checker for the inference block, bound to the top level.
module mlp_checker import mlp_pkg::*; (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic [1:0]  s_req_type,
    input logic        s_last,
    input logic        m_valid,
    input logic        m_ready,
    input logic [3:0]  m_class_index,
    input logic [15:0] m_best_logit
);
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_class_index) && $stable(m_best_logit))
        else $error("result beat changed while stalled");

    a_no_take_while_out: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !s_ready)
        else $error("input taken while result pending");

    a_start_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_req_type == REQ_FEATURE && s_last |=> !s_ready && !m_valid)
        else $error("inference start did not hold off input");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");
endmodule

bind mlp_relu_inference_argmax mlp_checker u_chk (
    .aclk, .aresetn, .s_valid, .s_ready, .s_req_type, .s_last,
    .m_valid, .m_ready, .m_class_index, .m_best_logit);
